FILE: rtl/ppd_pkg.sv
`default_nettype none
package ppd_pkg;

  localparam int BUFFER_BYTES = 120;
  localparam int IDX_W        = $clog2(BUFFER_BYTES);
  localparam int MIN_SIZE     = 4;
  localparam int POS_SIZE     = 24;

  typedef enum logic [1:0] {
    REPORT_POSITION  = 2'd0,
    REPORT_BAD_SIZE  = 2'd1,
    REPORT_SHORT_POS = 2'd2
  } report_kind_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               restart;
    logic signed [63:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    report_kind_t       report_kind;
    logic signed [63:0] server_time;
    logic [31:0]        right_ascension;
    logic signed [31:0] declination;
    logic signed [31:0] mount_status;
    logic signed [63:0] client_time;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/position_packet_deframer.sv
// Position packet deframer.
// Input channel (in_valid/in_ready/in_data) carries one stream byte per
// transfer with its local arrival time, or a restart marker. Packets start
// with a little-endian 16-bit size and 16-bit type; type-0 packets of 24
// bytes or more give a position report on their last byte.
// Result channel (out_valid/out_ready/out_data) carries position reports and
// error reports (bad size on the second byte, short position packet on the
// last byte); an error halts the parser until a restart transfer.
// A result appears in the cycle after the input transfer that causes it.
// Throughput: one byte per cycle while in_ready is high; the parser is
// a single counter step and byte insert between input and result register.
// A single result register holds the pending report. in_ready drops only
// while that register is full and out_ready is low; it rises again in the
// cycle the receiver takes the report.
// Reset (rst_n low, synchronous) clears the parser, the halt flag and the
// result valid flag; the result data register is not reset.
`default_nettype none
module position_packet_deframer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ppd_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ppd_pkg::out_item_t   out_data
);
  import ppd_pkg::*;

  logic               halted_r, halted_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]        size_r, size_nxt;
  logic [15:0]        type_r, type_nxt;
  logic [63:0]        time_acc_r, time_acc_nxt;
  logic [31:0]        ra_acc_r, ra_acc_nxt;
  logic [31:0]        dec_acc_r, dec_acc_nxt;
  logic [31:0]        stat_acc_r, stat_acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               fire;
  report_kind_t       kind;
  logic               size_bad;
  logic               last_byte;
  logic [15:0]        idx_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_ext   = {{(16-IDX_W){1'b0}}, idx_r};

  always_comb begin
    halted_nxt   = halted_r;
    idx_nxt      = idx_r;
    size_nxt     = size_r;
    type_nxt     = type_r;
    time_acc_nxt = time_acc_r;
    ra_acc_nxt   = ra_acc_r;
    dec_acc_nxt  = dec_acc_r;
    stat_acc_nxt = stat_acc_r;
    fire         = 1'b0;
    kind         = REPORT_POSITION;
    size_bad     = 1'b0;
    last_byte    = 1'b0;
    if (accept) begin
      if (in_data.restart) begin
        halted_nxt   = 1'b0;
        idx_nxt      = '0;
        size_nxt     = '0;
        type_nxt     = '0;
        time_acc_nxt = '0;
        ra_acc_nxt   = '0;
        dec_acc_nxt  = '0;
        stat_acc_nxt = '0;
      end else if (!halted_r) begin
        if (idx_r == IDX_W'(0)) begin
          size_nxt     = {8'h00, in_data.data_byte};
          type_nxt     = '0;
          time_acc_nxt = '0;
          ra_acc_nxt   = '0;
          dec_acc_nxt  = '0;
          stat_acc_nxt = '0;
        end else if (idx_r == IDX_W'(1)) begin
          size_nxt = {in_data.data_byte, size_r[7:0]};
          size_bad = (size_nxt < 16'(MIN_SIZE)) || (size_nxt > 16'(BUFFER_BYTES));
        end else if (idx_r == IDX_W'(2)) begin
          type_nxt = {8'h00, in_data.data_byte};
        end else if (idx_r == IDX_W'(3)) begin
          type_nxt = {in_data.data_byte, type_r[7:0]};
        end
        for (int k = 0; k < 8; k++) begin
          if (idx_r == IDX_W'(4 + k)) begin
            time_acc_nxt[8*k +: 8] = time_acc_r[8*k +: 8] | in_data.data_byte;
          end
        end
        for (int k = 0; k < 4; k++) begin
          if (idx_r == IDX_W'(12 + k)) begin
            ra_acc_nxt[8*k +: 8] = ra_acc_r[8*k +: 8] | in_data.data_byte;
          end
          if (idx_r == IDX_W'(16 + k)) begin
            dec_acc_nxt[8*k +: 8] = dec_acc_r[8*k +: 8] | in_data.data_byte;
          end
          if (idx_r == IDX_W'(20 + k)) begin
            stat_acc_nxt[8*k +: 8] = stat_acc_r[8*k +: 8] | in_data.data_byte;
          end
        end
        last_byte = (idx_r != IDX_W'(0)) && ((idx_ext + 16'd1) >= size_nxt);
        if (size_bad) begin
          halted_nxt = 1'b1;
          idx_nxt    = '0;
          fire       = 1'b1;
          kind       = REPORT_BAD_SIZE;
        end else if (last_byte) begin
          idx_nxt = '0;
          if (type_nxt == 16'd0) begin
            fire = 1'b1;
            if (size_nxt < 16'(POS_SIZE)) begin
              halted_nxt = 1'b1;
              kind       = REPORT_SHORT_POS;
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (accept && fire) begin
      out_data_nxt.report_kind = kind;
      if (kind == REPORT_POSITION) begin
        out_data_nxt.server_time     = time_acc_nxt;
        out_data_nxt.right_ascension = ra_acc_nxt;
        out_data_nxt.declination     = dec_acc_nxt;
        out_data_nxt.mount_status    = stat_acc_nxt;
        out_data_nxt.client_time     = in_data.arrival_time;
      end else begin
        out_data_nxt.server_time     = '0;
        out_data_nxt.right_ascension = '0;
        out_data_nxt.declination     = '0;
        out_data_nxt.mount_status    = '0;
        out_data_nxt.client_time     = '0;
      end
    end
    if (accept) begin
      out_valid_nxt = fire;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      idx_r       <= '0;
      size_r      <= '0;
      type_r      <= '0;
      time_acc_r  <= '0;
      ra_acc_r    <= '0;
      dec_acc_r   <= '0;
      stat_acc_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      halted_r    <= halted_nxt;
      idx_r       <= idx_nxt;
      size_r      <= size_nxt;
      type_r      <= type_nxt;
      time_acc_r  <= time_acc_nxt;
      ra_acc_r    <= ra_acc_nxt;
      dec_acc_r   <= dec_acc_nxt;
      stat_acc_r  <= stat_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_halt_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> idx_r == '0)
    else $error("parser halted with nonzero byte index");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.restart |=> !halted_r && idx_r == '0 && !out_valid_r)
    else $error("restart did not clear parser");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.report_kind != REPORT_POSITION |->
      out_data_r.server_time == '0 && out_data_r.client_time == '0 &&
      out_data_r.mount_status == '0)
    else $error("error report carries payload");

  a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result without input transfer");
`endif

endmodule
`default_nettype wire

FILE: tb/position_packet_deframer_checker.sv
`timescale 1ns / 1ps
module position_packet_deframer_checker
  import ppd_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_ready,
  input  in_item_t  in_data,
  input  wire       out_valid,
  input  wire       out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        outstanding
);

  logic        halted;
  int unsigned frame_pos;
  logic [15:0] frame_size;
  logic [15:0] frame_kind;
  logic [63:0] time_acc;
  logic [31:0] ra_acc;
  logic [31:0] dec_acc;
  logic [31:0] status_acc;
  out_item_t   reports[$];

  task automatic clear_parser();
    frame_pos  = 0;
    frame_size = '0;
    frame_kind = '0;
    time_acc   = '0;
    ra_acc     = '0;
    dec_acc    = '0;
    status_acc = '0;
  endtask

  task automatic deframe(input in_item_t item);
    out_item_t  rpt;
    logic [7:0] b;
    b   = item.data_byte;
    rpt = '0;
    if (item.restart) begin
      halted = 1'b0;
      clear_parser();
      return;
    end
    if (halted) return;

    if (frame_pos == 0) begin
      clear_parser();
      frame_size = {8'h00, b};
    end else if (frame_pos == 1) begin
      frame_size[15:8] = b;
      if (frame_size < 16'(MIN_SIZE) || frame_size > 16'(BUFFER_BYTES)) begin
        halted          = 1'b1;
        frame_pos       = 0;
        rpt.report_kind = REPORT_BAD_SIZE;
        reports.push_back(rpt);
        return;
      end
    end else if (frame_pos == 2) begin
      frame_kind[7:0] = b;
    end else if (frame_pos == 3) begin
      frame_kind[15:8] = b;
    end else if (frame_pos < 12) begin
      time_acc[8*(frame_pos-4) +: 8] = b;
    end else if (frame_pos < 16) begin
      ra_acc[8*(frame_pos-12) +: 8] = b;
    end else if (frame_pos < 20) begin
      dec_acc[8*(frame_pos-16) +: 8] = b;
    end else if (frame_pos < 24) begin
      status_acc[8*(frame_pos-20) +: 8] = b;
    end

    if (frame_pos >= 1 && frame_pos + 1 >= 32'(frame_size)) begin
      frame_pos = 0;
      if (frame_kind == 16'h0000) begin
        if (frame_size < 16'(POS_SIZE)) begin
          halted          = 1'b1;
          rpt.report_kind = REPORT_SHORT_POS;
        end else begin
          rpt.report_kind     = REPORT_POSITION;
          rpt.server_time     = time_acc;
          rpt.right_ascension = ra_acc;
          rpt.declination     = dec_acc;
          rpt.mount_status    = status_acc;
          rpt.client_time     = item.arrival_time;
        end
        reports.push_back(rpt);
      end
    end else begin
      frame_pos++;
    end
  endtask

  function automatic void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      halted = 1'b0;
      clear_parser();
      reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual kind %0d data 0x%0h",
                   $time, out_data.report_kind, out_data);
        end else begin
          want = reports.pop_front();
          if (out_data.report_kind !== want.report_kind)
            report_mismatch("report_kind", 64'(want.report_kind),
                            64'(out_data.report_kind));
          if (out_data.server_time !== want.server_time)
            report_mismatch("server_time", want.server_time, out_data.server_time);
          if (out_data.right_ascension !== want.right_ascension)
            report_mismatch("right_ascension", 64'(want.right_ascension),
                            64'(out_data.right_ascension));
          if (out_data.declination !== want.declination)
            report_mismatch("declination", 64'(want.declination),
                            64'(out_data.declination));
          if (out_data.mount_status !== want.mount_status)
            report_mismatch("mount_status", 64'(want.mount_status),
                            64'(out_data.mount_status));
          if (out_data.client_time !== want.client_time)
            report_mismatch("client_time", want.client_time, out_data.client_time);
        end
      end
      if (in_valid && in_ready) deframe(in_data);
    end
    outstanding <= reports.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ppd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int STREAM_BYTES = 1400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        outstanding;
  int        cycles;
  int        bytes_sent;
  bit        calm;

  position_packet_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  position_packet_deframer_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** position_packet_deframer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 34);

  task automatic send_item(input logic [7:0] value, input bit restart);
    in_item_t item;
    int       pick;
    pick           = $urandom_range(15);
    item.data_byte = value;
    item.restart   = restart;
    case (pick)
      0:       item.arrival_time = 64'h7FFF_FFFF_FFFF_FFFF;
      1:       item.arrival_time = 64'h8000_0000_0000_0000;
      2:       item.arrival_time = '0;
      default: item.arrival_time = {$urandom, $urandom};
    endcase
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_restart();
    send_item(8'($urandom), 1'b1);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] size, input logic [15:0] kind, input int count);
    int         fill;
    logic [7:0] value;
    fill = $urandom_range(3);
    for (int i = 0; i < count; i++) begin
      case (i)
        0:       value = size[7:0];
        1:       value = size[15:8];
        2:       value = kind[7:0];
        3:       value = kind[15:8];
        default: value = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom);
      endcase
      send_item(value, 1'b0);
    end
    bytes_sent += count;
  endtask

  function automatic logic [15:0] position_size();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'(BUFFER_BYTES);
    if (pick == 1) return 16'($urandom_range(POS_SIZE + 9, BUFFER_BYTES - 1));
    return 16'($urandom_range(POS_SIZE, POS_SIZE + 8));
  endfunction

  initial begin
    int          frames;
    int          pick;
    int          count;
    logic [15:0] size;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_restart();
    send_frame(16'd4, 16'h0100, 4);
    send_frame(16'd4, 16'h0000, 4);
    send_item(8'hA5, 1'b0);
    send_restart();
    send_frame(16'd3, 16'h0000, 2);
    send_restart();
    send_frame(16'(BUFFER_BYTES + 1), 16'h0000, 2);
    send_restart();
    send_frame(16'hFFFF, 16'h0000, 2);
    send_restart();
    send_frame(16'h0000, 16'h0000, 2);
    send_restart();

    frames = 0;
    while (bytes_sent < STREAM_BYTES) begin
      frames++;
      calm = (frames >= 15 && frames < 30);
      pick = $urandom_range(99);
      if (pick < 55) begin
        size = position_size();
        send_frame(size, 16'h0000, int'(size));
      end else if (pick < 67) begin
        size = ($urandom_range(7) == 0) ? 16'(BUFFER_BYTES) : 16'($urandom_range(MIN_SIZE, 40));
        send_frame(size, 16'($urandom_range(1, 65535)), int'(size));
      end else if (pick < 77) begin
        size = 16'($urandom_range(MIN_SIZE, POS_SIZE - 1));
        send_frame(size, 16'h0000, int'(size));
        repeat ($urandom_range(3)) send_item(8'($urandom), 1'b0);
        send_restart();
      end else if (pick < 85) begin
        if ($urandom_range(1) == 0)
          size = 16'($urandom_range(0, MIN_SIZE - 1));
        else if ($urandom_range(3) == 0)
          size = 16'(BUFFER_BYTES + 1);
        else
          size = 16'($urandom_range(BUFFER_BYTES + 2, 65535));
        send_frame(size, 16'($urandom), 2);
        repeat ($urandom_range(3)) send_item(8'($urandom), 1'b0);
        send_restart();
      end else if (pick < 93) begin
        size = position_size();
        send_frame(size, 16'h0000, $urandom_range(1, int'(size) - 1));
        send_restart();
      end else begin
        count = $urandom_range(1, 8);
        repeat (count) send_item(8'($urandom), 1'b0);
        bytes_sent += count;
        send_restart();
      end

      if (frames == 40) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("** position_packet_deframer: PASSED **");
    else
      $display("** position_packet_deframer: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ppd_pkg.sv
rtl/position_packet_deframer.sv
tb/position_packet_deframer_checker.sv
tb/testbench.sv
